>>> hdl/clsx_pkg.sv
// Shared state codes, token codes and result type for the C subset lexer.
package clsx_pkg;

  localparam int STATE_BITS = 6;
  localparam int TOKEN_BITS = 9;
  localparam int OUT_POS_BITS = 16;

  // Scan states
  localparam logic [STATE_BITS-1:0] ST_START       = 6'd1;
  localparam logic [STATE_BITS-1:0] ST_SLASH       = 6'd2;
  localparam logic [STATE_BITS-1:0] ST_COMMENT     = 6'd3;
  localparam logic [STATE_BITS-1:0] ST_COMMENT_END = 6'd4;
  localparam logic [STATE_BITS-1:0] ST_STR         = 6'd5;
  localparam logic [STATE_BITS-1:0] ST_STR_END     = 6'd6;
  localparam logic [STATE_BITS-1:0] ST_LT          = 6'd7;
  localparam logic [STATE_BITS-1:0] ST_LE          = 6'd8;
  localparam logic [STATE_BITS-1:0] ST_GT          = 6'd9;
  localparam logic [STATE_BITS-1:0] ST_GE          = 6'd10;
  localparam logic [STATE_BITS-1:0] ST_ASSIGN      = 6'd11;
  localparam logic [STATE_BITS-1:0] ST_EQ          = 6'd12;
  localparam logic [STATE_BITS-1:0] ST_NOT         = 6'd13;
  localparam logic [STATE_BITS-1:0] ST_NE          = 6'd14;
  localparam logic [STATE_BITS-1:0] ST_PLUS        = 6'd15;
  localparam logic [STATE_BITS-1:0] ST_INCR        = 6'd16;
  localparam logic [STATE_BITS-1:0] ST_MINUS       = 6'd17;
  localparam logic [STATE_BITS-1:0] ST_DECR        = 6'd18;
  localparam logic [STATE_BITS-1:0] ST_STAR        = 6'd19;
  localparam logic [STATE_BITS-1:0] ST_AMP         = 6'd20;
  localparam logic [STATE_BITS-1:0] ST_AND         = 6'd21;
  localparam logic [STATE_BITS-1:0] ST_BAR         = 6'd22;
  localparam logic [STATE_BITS-1:0] ST_OR          = 6'd23;
  localparam logic [STATE_BITS-1:0] ST_IDENT       = 6'd24;
  localparam logic [STATE_BITS-1:0] ST_INT         = 6'd25;
  localparam logic [STATE_BITS-1:0] ST_DOT         = 6'd26;
  localparam logic [STATE_BITS-1:0] ST_FLOAT       = 6'd27;
  localparam logic [STATE_BITS-1:0] ST_EXP         = 6'd28;
  localparam logic [STATE_BITS-1:0] ST_EXP_SIGN    = 6'd29;
  localparam logic [STATE_BITS-1:0] ST_EXP_NUM     = 6'd30;
  localparam logic [STATE_BITS-1:0] ST_HASH        = 6'd31;
  // #include directive letters seen so far
  localparam logic [STATE_BITS-1:0] ST_PP_I        = 6'd32;
  localparam logic [STATE_BITS-1:0] ST_PP_N        = 6'd33;
  localparam logic [STATE_BITS-1:0] ST_PP_C        = 6'd34;
  localparam logic [STATE_BITS-1:0] ST_PP_L        = 6'd35;
  localparam logic [STATE_BITS-1:0] ST_PP_U        = 6'd36;
  localparam logic [STATE_BITS-1:0] ST_PP_D        = 6'd37;
  localparam logic [STATE_BITS-1:0] ST_PP_DONE     = 6'd38;

  // Token codes
  localparam logic [TOKEN_BITS-1:0] TOK_ERROR    = 9'd0;
  localparam logic [TOKEN_BITS-1:0] TOK_INCLUDE  = 9'd115;
  localparam logic [TOKEN_BITS-1:0] TOK_COMMENT  = 9'd200;
  localparam logic [TOKEN_BITS-1:0] TOK_STRING   = 9'd201;
  localparam logic [TOKEN_BITS-1:0] TOK_ASSIGN   = 9'd202;
  localparam logic [TOKEN_BITS-1:0] TOK_IDENT    = 9'd203;
  localparam logic [TOKEN_BITS-1:0] TOK_INT      = 9'd204;
  localparam logic [TOKEN_BITS-1:0] TOK_FLOAT    = 9'd205;
  localparam logic [TOKEN_BITS-1:0] TOK_EXP_NUM  = 9'd206;
  localparam logic [TOKEN_BITS-1:0] TOK_LT       = 9'd300;
  localparam logic [TOKEN_BITS-1:0] TOK_LE       = 9'd301;
  localparam logic [TOKEN_BITS-1:0] TOK_GT       = 9'd302;
  localparam logic [TOKEN_BITS-1:0] TOK_GE       = 9'd303;
  localparam logic [TOKEN_BITS-1:0] TOK_EQ       = 9'd304;
  localparam logic [TOKEN_BITS-1:0] TOK_NE       = 9'd305;
  localparam logic [TOKEN_BITS-1:0] TOK_NOT      = 9'd400;
  localparam logic [TOKEN_BITS-1:0] TOK_AND      = 9'd401;
  localparam logic [TOKEN_BITS-1:0] TOK_OR       = 9'd402;
  localparam logic [TOKEN_BITS-1:0] TOK_PLUS     = 9'd500;
  localparam logic [TOKEN_BITS-1:0] TOK_INCR     = 9'd501;
  localparam logic [TOKEN_BITS-1:0] TOK_MINUS    = 9'd502;
  localparam logic [TOKEN_BITS-1:0] TOK_DECR     = 9'd503;
  localparam logic [TOKEN_BITS-1:0] TOK_STAR     = 9'd504;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic                  valid;
    logic                  is_error;
    logic [TOKEN_BITS-1:0] token_code;
  } emit_t;

endpackage

>>> hdl/clsx_scan.sv
// Next-state and token emission logic of the lexer state machine.
module clsx_scan (
  input  logic [clsx_pkg::STATE_BITS-1:0] state,
  input  logic [7:0]                      char_code,
  input  logic                            end_of_input,
  output logic [clsx_pkg::STATE_BITS-1:0] state_next,
  output clsx_pkg::emit_t                 result
);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_I  = 8'h69;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_C  = 8'h63;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_LO_D  = 8'h64;

  function automatic logic [clsx_pkg::STATE_BITS-1:0] step(
    input logic [clsx_pkg::STATE_BITS-1:0] s,
    input logic [7:0]                      c
  );
    logic alpha;
    logic digit;
    logic is_e;
    logic [clsx_pkg::STATE_BITS-1:0] n;
    alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    digit = (c >= 8'h30 && c <= 8'h39);
    is_e  = (c == CH_UP_E) || (c == CH_LO_E);
    n = clsx_pkg::ST_START;
    case (s)
      clsx_pkg::ST_START: begin
        if (c == CH_SLASH)      n = clsx_pkg::ST_SLASH;
        else if (c == CH_QUOTE) n = clsx_pkg::ST_STR;
        else if (c == CH_LT)    n = clsx_pkg::ST_LT;
        else if (c == CH_GT)    n = clsx_pkg::ST_GT;
        else if (c == CH_EQ)    n = clsx_pkg::ST_ASSIGN;
        else if (c == CH_BANG)  n = clsx_pkg::ST_NOT;
        else if (c == CH_PLUS)  n = clsx_pkg::ST_PLUS;
        else if (c == CH_MINUS) n = clsx_pkg::ST_MINUS;
        else if (c == CH_STAR)  n = clsx_pkg::ST_STAR;
        else if (c == CH_AMP)   n = clsx_pkg::ST_AMP;
        else if (c == CH_BAR)   n = clsx_pkg::ST_BAR;
        else if (alpha)         n = clsx_pkg::ST_IDENT;
        else if (digit)         n = clsx_pkg::ST_INT;
        else if (c == CH_HASH)  n = clsx_pkg::ST_HASH;
      end
      clsx_pkg::ST_SLASH:   if (c == CH_SLASH) n = clsx_pkg::ST_COMMENT;
      clsx_pkg::ST_COMMENT:
        n = (c == clsx_pkg::CH_NEWLINE) ? clsx_pkg::ST_COMMENT_END : clsx_pkg::ST_COMMENT;
      clsx_pkg::ST_STR:     n = (c == CH_QUOTE) ? clsx_pkg::ST_STR_END : clsx_pkg::ST_STR;
      clsx_pkg::ST_LT:      if (c == CH_EQ) n = clsx_pkg::ST_LE;
      clsx_pkg::ST_GT:      if (c == CH_EQ) n = clsx_pkg::ST_GE;
      clsx_pkg::ST_ASSIGN:  if (c == CH_EQ) n = clsx_pkg::ST_EQ;
      clsx_pkg::ST_NOT:     if (c == CH_EQ) n = clsx_pkg::ST_NE;
      clsx_pkg::ST_PLUS:    if (c == CH_PLUS) n = clsx_pkg::ST_INCR;
      clsx_pkg::ST_MINUS:   if (c == CH_MINUS) n = clsx_pkg::ST_DECR;
      clsx_pkg::ST_AMP:     if (c == CH_AMP) n = clsx_pkg::ST_AND;
      clsx_pkg::ST_BAR:     if (c == CH_BAR) n = clsx_pkg::ST_OR;
      clsx_pkg::ST_IDENT:   if (alpha || digit || c == CH_UNDER) n = clsx_pkg::ST_IDENT;
      clsx_pkg::ST_INT: begin
        if (digit)            n = clsx_pkg::ST_INT;
        else if (c == CH_DOT) n = clsx_pkg::ST_DOT;
        else if (is_e)        n = clsx_pkg::ST_EXP;
      end
      clsx_pkg::ST_DOT:     if (digit) n = clsx_pkg::ST_FLOAT;
      clsx_pkg::ST_FLOAT:   if (is_e) n = clsx_pkg::ST_EXP;
      clsx_pkg::ST_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS) n = clsx_pkg::ST_EXP_SIGN;
        else if (digit)                    n = clsx_pkg::ST_EXP_NUM;
      end
      clsx_pkg::ST_EXP_SIGN, clsx_pkg::ST_EXP_NUM: if (digit) n = clsx_pkg::ST_EXP_NUM;
      clsx_pkg::ST_HASH:    if (c == CH_LO_I) n = clsx_pkg::ST_PP_I;
      clsx_pkg::ST_PP_I:    if (c == CH_LO_N) n = clsx_pkg::ST_PP_N;
      clsx_pkg::ST_PP_N:    if (c == CH_LO_C) n = clsx_pkg::ST_PP_C;
      clsx_pkg::ST_PP_C:    if (c == CH_LO_L) n = clsx_pkg::ST_PP_L;
      clsx_pkg::ST_PP_L:    if (c == CH_LO_U) n = clsx_pkg::ST_PP_U;
      clsx_pkg::ST_PP_U:    if (c == CH_LO_D) n = clsx_pkg::ST_PP_D;
      clsx_pkg::ST_PP_D:    if (c == CH_LO_E) n = clsx_pkg::ST_PP_DONE;
      default:              n = clsx_pkg::ST_START;
    endcase
    return n;
  endfunction

  function automatic logic [clsx_pkg::TOKEN_BITS-1:0] accept_code(
    input logic [clsx_pkg::STATE_BITS-1:0] s
  );
    logic [clsx_pkg::TOKEN_BITS-1:0] t;
    case (s)
      clsx_pkg::ST_COMMENT_END: t = clsx_pkg::TOK_COMMENT;
      clsx_pkg::ST_STR_END:     t = clsx_pkg::TOK_STRING;
      clsx_pkg::ST_LT:          t = clsx_pkg::TOK_LT;
      clsx_pkg::ST_LE:          t = clsx_pkg::TOK_LE;
      clsx_pkg::ST_GT:          t = clsx_pkg::TOK_GT;
      clsx_pkg::ST_GE:          t = clsx_pkg::TOK_GE;
      clsx_pkg::ST_ASSIGN:      t = clsx_pkg::TOK_ASSIGN;
      clsx_pkg::ST_EQ:          t = clsx_pkg::TOK_EQ;
      clsx_pkg::ST_NOT:         t = clsx_pkg::TOK_NOT;
      clsx_pkg::ST_NE:          t = clsx_pkg::TOK_NE;
      clsx_pkg::ST_PLUS:        t = clsx_pkg::TOK_PLUS;
      clsx_pkg::ST_INCR:        t = clsx_pkg::TOK_INCR;
      clsx_pkg::ST_MINUS:       t = clsx_pkg::TOK_MINUS;
      clsx_pkg::ST_DECR:        t = clsx_pkg::TOK_DECR;
      clsx_pkg::ST_STAR:        t = clsx_pkg::TOK_STAR;
      clsx_pkg::ST_AND:         t = clsx_pkg::TOK_AND;
      clsx_pkg::ST_OR:          t = clsx_pkg::TOK_OR;
      clsx_pkg::ST_IDENT:       t = clsx_pkg::TOK_IDENT;
      clsx_pkg::ST_INT:         t = clsx_pkg::TOK_INT;
      clsx_pkg::ST_FLOAT:       t = clsx_pkg::TOK_FLOAT;
      clsx_pkg::ST_EXP_NUM:     t = clsx_pkg::TOK_EXP_NUM;
      clsx_pkg::ST_PP_DONE:     t = clsx_pkg::TOK_INCLUDE;
      default:                  t = clsx_pkg::TOK_ERROR;
    endcase
    return t;
  endfunction

  logic [clsx_pkg::STATE_BITS-1:0] cont_state;
  logic [clsx_pkg::STATE_BITS-1:0] restart_state;
  logic [clsx_pkg::TOKEN_BITS-1:0] code;
  logic                            in_token;

  assign cont_state    = step(state, char_code);
  assign restart_state = step(clsx_pkg::ST_START, char_code);
  assign code          = accept_code(state);
  assign in_token      = (state != clsx_pkg::ST_START);

  always_comb begin
    result.token_code = code;
    result.is_error   = (code == clsx_pkg::TOK_ERROR);
    if (end_of_input) begin
      // flush whatever is pending and go back to start
      result.valid = in_token;
      state_next   = clsx_pkg::ST_START;
    end else if (in_token && cont_state == clsx_pkg::ST_START) begin
      // token ended: emit it and rescan the terminating character
      result.valid = 1'b1;
      state_next   = restart_state;
    end else begin
      result.valid = 1'b0;
      state_next   = cont_state;
    end
  end

endmodule

>>> hdl/c_subset_lexer_dfa.sv
// Top level of the C subset lexer: position counters, scan state and result register.
//
// Input stream: one source byte per transaction on s_axis_tdata[7:0]; s_axis_tlast set
// flushes the token in progress and the byte is ignored.
// Output stream: one transaction per finished token, carrying the token code (0 on
// error), line and column in m_axis_tdata and the error flag in m_axis_tuser.
// Output: each result is registered and appears on m_axis in the cycle after the byte
// ending the token (or the flush) is accepted. Throughput: one byte per cycle while no
// result stalls; the next state is a single combinational function of state and byte.
// Whitespace and unknown bytes between tokens produce no output.
// Stall: s_axis_tready is high while the result register is empty or being taken
// this cycle; a stalled result holds and input stops until it leaves.
// Reset: scan state returns to start, line count to 1, column count to 0, and the
// result register empties. Line and column counters saturate at their maximum and
// are reported clamped to 16 bits.
module c_subset_lexer_dfa #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [8:0] token_code, [24:9] line_number,
                                      // [40:25] column_number, [47:41] zero
  output logic        m_axis_tuser    // is_error
);

  localparam int WIDE_BITS = (POSITION_BITS > clsx_pkg::OUT_POS_BITS) ?
                             POSITION_BITS : clsx_pkg::OUT_POS_BITS;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [WIDE_BITS-1:0] OUT_MAX = WIDE_BITS'({clsx_pkg::OUT_POS_BITS{1'b1}});

  logic [clsx_pkg::STATE_BITS-1:0] state;
  logic [clsx_pkg::STATE_BITS-1:0] state_next;
  logic [POSITION_BITS-1:0]        line_count;
  logic [POSITION_BITS-1:0]        line_count_next;
  logic [POSITION_BITS-1:0]        column_count;
  logic [POSITION_BITS-1:0]        column_count_next;
  clsx_pkg::emit_t                 result;
  logic                            accept;
  logic [WIDE_BITS-1:0]            line_wide;
  logic [WIDE_BITS-1:0]            column_wide;
  logic [clsx_pkg::OUT_POS_BITS-1:0] line_sat;
  logic [clsx_pkg::OUT_POS_BITS-1:0] column_sat;

  logic                              out_valid;
  logic [clsx_pkg::TOKEN_BITS-1:0]   out_token;
  logic                              out_error;
  logic [clsx_pkg::OUT_POS_BITS-1:0] out_line;
  logic [clsx_pkg::OUT_POS_BITS-1:0] out_column;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  clsx_scan u_scan (
    .state        (state),
    .char_code    (s_axis_tdata),
    .end_of_input (s_axis_tlast),
    .state_next   (state_next),
    .result       (result)
  );

  // advance position on every real character; newline starts a new line at column 0
  always_comb begin
    line_count_next   = line_count;
    column_count_next = column_count;
    if (!s_axis_tlast) begin
      if (column_count != POS_MAX) column_count_next = column_count + 1'b1;
      if (s_axis_tdata == clsx_pkg::CH_NEWLINE) begin
        if (line_count != POS_MAX) line_count_next = line_count + 1'b1;
        column_count_next = '0;
      end
    end
  end

  assign line_wide   = WIDE_BITS'(line_count_next);
  assign column_wide = WIDE_BITS'(column_count_next);
  assign line_sat    = (line_wide > OUT_MAX) ? '1 : line_wide[clsx_pkg::OUT_POS_BITS-1:0];
  assign column_sat  = (column_wide > OUT_MAX) ? '1 : column_wide[clsx_pkg::OUT_POS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= clsx_pkg::ST_START;
      line_count   <= POSITION_BITS'(1);
      column_count <= '0;
    end else if (accept) begin
      state        <= state_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= result.valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // payload: load only when a token is emitted
  always_ff @(posedge clk) begin
    if (accept && result.valid) begin
      out_token  <= result.token_code;
      out_error  <= result.is_error;
      out_line   <= line_sat;
      out_column <= column_sat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_column, out_line, out_token};
  assign m_axis_tuser  = out_error;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the C subset lexer: byte stream in, checked token stream out.
module testbench;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         hold;
  } src_byte_t;

  typedef struct {
    logic [clsx_pkg::TOKEN_BITS-1:0] code;
    logic                            err;
    logic [15:0]                     line;
    logic [15:0]                     col;
  } lex_token_t;

  typedef enum int {
    K_IDENT, K_INT, K_FLOAT, K_EXP, K_INCLUDE, K_COMMENT, K_STRING, K_OP, K_OP_PAIR,
    K_BROKEN_NUM, K_BROKEN_PP, K_SLASH, K_NOISE, K_FLUSH, K_COUNT
  } lex_kind_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_code
  logic        s_axis_tlast = 1'b0;    // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;           // [8:0] token_code, [24:9] line, [40:25] column
  logic        m_axis_tuser;           // is_error

  src_byte_t   source_bytes[$];
  lex_token_t  awaited_tokens[$];
  logic [5:0]  scan_st = clsx_pkg::ST_START;
  logic [15:0] line_cnt = 16'd1;
  logic [15:0] col_cnt = 16'd0;
  logic        in_fire = 1'b0;
  bit          hold_next = 1'b0;
  int          n_chars = 0;
  int          n_tokens = 0;
  int          n_err_tokens = 0;
  int          n_flushes = 0;
  int          n_mismatch = 0;

  string op_text[17] = '{"<", "<=", ">", ">=", "=", "==", "!", "!=", "+", "++", "-", "--",
                         "*", "&", "&&", "|", "||"};

  c_subset_lexer_dfa i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [5:0] advance_state(logic [5:0] st, logic [7:0] c);
    logic letter;
    logic digit;
    letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    digit  = (c >= "0" && c <= "9");
    case (st)
      clsx_pkg::ST_START: begin
        if (c == "/") return clsx_pkg::ST_SLASH;
        if (c == "\"") return clsx_pkg::ST_STR;
        if (c == "<") return clsx_pkg::ST_LT;
        if (c == ">") return clsx_pkg::ST_GT;
        if (c == "=") return clsx_pkg::ST_ASSIGN;
        if (c == "!") return clsx_pkg::ST_NOT;
        if (c == "+") return clsx_pkg::ST_PLUS;
        if (c == "-") return clsx_pkg::ST_MINUS;
        if (c == "*") return clsx_pkg::ST_STAR;
        if (c == "&") return clsx_pkg::ST_AMP;
        if (c == "|") return clsx_pkg::ST_BAR;
        if (letter) return clsx_pkg::ST_IDENT;
        if (digit) return clsx_pkg::ST_INT;
        if (c == "#") return clsx_pkg::ST_HASH;
        return clsx_pkg::ST_START;
      end
      clsx_pkg::ST_SLASH:
        return (c == "/") ? clsx_pkg::ST_COMMENT : clsx_pkg::ST_START;
      clsx_pkg::ST_COMMENT:
        return (c == clsx_pkg::CH_NEWLINE) ? clsx_pkg::ST_COMMENT_END : clsx_pkg::ST_COMMENT;
      clsx_pkg::ST_STR:
        return (c == "\"") ? clsx_pkg::ST_STR_END : clsx_pkg::ST_STR;
      clsx_pkg::ST_LT, clsx_pkg::ST_GT, clsx_pkg::ST_ASSIGN, clsx_pkg::ST_NOT:
        return (c == "=") ? st + 6'd1 : clsx_pkg::ST_START;
      clsx_pkg::ST_PLUS:
        return (c == "+") ? clsx_pkg::ST_INCR : clsx_pkg::ST_START;
      clsx_pkg::ST_MINUS:
        return (c == "-") ? clsx_pkg::ST_DECR : clsx_pkg::ST_START;
      clsx_pkg::ST_AMP:
        return (c == "&") ? clsx_pkg::ST_AND : clsx_pkg::ST_START;
      clsx_pkg::ST_BAR:
        return (c == "|") ? clsx_pkg::ST_OR : clsx_pkg::ST_START;
      clsx_pkg::ST_IDENT:
        return (letter || digit || c == "_") ? clsx_pkg::ST_IDENT : clsx_pkg::ST_START;
      clsx_pkg::ST_INT: begin
        if (digit) return clsx_pkg::ST_INT;
        if (c == ".") return clsx_pkg::ST_DOT;
        if (c == "E" || c == "e") return clsx_pkg::ST_EXP;
        return clsx_pkg::ST_START;
      end
      clsx_pkg::ST_DOT:
        return digit ? clsx_pkg::ST_FLOAT : clsx_pkg::ST_START;
      clsx_pkg::ST_FLOAT:
        return (c == "E" || c == "e") ? clsx_pkg::ST_EXP : clsx_pkg::ST_START;
      clsx_pkg::ST_EXP: begin
        if (c == "+" || c == "-") return clsx_pkg::ST_EXP_SIGN;
        if (digit) return clsx_pkg::ST_EXP_NUM;
        return clsx_pkg::ST_START;
      end
      clsx_pkg::ST_EXP_SIGN, clsx_pkg::ST_EXP_NUM:
        return digit ? clsx_pkg::ST_EXP_NUM : clsx_pkg::ST_START;
      clsx_pkg::ST_HASH:
        return (c == "i") ? clsx_pkg::ST_PP_I : clsx_pkg::ST_START;
      clsx_pkg::ST_PP_I:
        return (c == "n") ? clsx_pkg::ST_PP_N : clsx_pkg::ST_START;
      clsx_pkg::ST_PP_N:
        return (c == "c") ? clsx_pkg::ST_PP_C : clsx_pkg::ST_START;
      clsx_pkg::ST_PP_C:
        return (c == "l") ? clsx_pkg::ST_PP_L : clsx_pkg::ST_START;
      clsx_pkg::ST_PP_L:
        return (c == "u") ? clsx_pkg::ST_PP_U : clsx_pkg::ST_START;
      clsx_pkg::ST_PP_U:
        return (c == "d") ? clsx_pkg::ST_PP_D : clsx_pkg::ST_START;
      clsx_pkg::ST_PP_D:
        return (c == "e") ? clsx_pkg::ST_PP_DONE : clsx_pkg::ST_START;
      default:
        return clsx_pkg::ST_START;
    endcase
  endfunction

  function automatic logic [clsx_pkg::TOKEN_BITS-1:0] token_of(logic [5:0] st);
    case (st)
      clsx_pkg::ST_COMMENT_END: return clsx_pkg::TOK_COMMENT;
      clsx_pkg::ST_STR_END:     return clsx_pkg::TOK_STRING;
      clsx_pkg::ST_LT:          return clsx_pkg::TOK_LT;
      clsx_pkg::ST_LE:          return clsx_pkg::TOK_LE;
      clsx_pkg::ST_GT:          return clsx_pkg::TOK_GT;
      clsx_pkg::ST_GE:          return clsx_pkg::TOK_GE;
      clsx_pkg::ST_ASSIGN:      return clsx_pkg::TOK_ASSIGN;
      clsx_pkg::ST_EQ:          return clsx_pkg::TOK_EQ;
      clsx_pkg::ST_NOT:         return clsx_pkg::TOK_NOT;
      clsx_pkg::ST_NE:          return clsx_pkg::TOK_NE;
      clsx_pkg::ST_PLUS:        return clsx_pkg::TOK_PLUS;
      clsx_pkg::ST_INCR:        return clsx_pkg::TOK_INCR;
      clsx_pkg::ST_MINUS:       return clsx_pkg::TOK_MINUS;
      clsx_pkg::ST_DECR:        return clsx_pkg::TOK_DECR;
      clsx_pkg::ST_STAR:        return clsx_pkg::TOK_STAR;
      clsx_pkg::ST_AND:         return clsx_pkg::TOK_AND;
      clsx_pkg::ST_OR:          return clsx_pkg::TOK_OR;
      clsx_pkg::ST_IDENT:       return clsx_pkg::TOK_IDENT;
      clsx_pkg::ST_INT:         return clsx_pkg::TOK_INT;
      clsx_pkg::ST_FLOAT:       return clsx_pkg::TOK_FLOAT;
      clsx_pkg::ST_EXP_NUM:     return clsx_pkg::TOK_EXP_NUM;
      clsx_pkg::ST_PP_DONE:     return clsx_pkg::TOK_INCLUDE;
      default:                  return clsx_pkg::TOK_ERROR;
    endcase
  endfunction

  task automatic await_token(logic [5:0] st);
    lex_token_t t;
    t.code = token_of(st);
    t.err  = (t.code == clsx_pkg::TOK_ERROR);
    t.line = line_cnt;
    t.col  = col_cnt;
    awaited_tokens.push_back(t);
  endtask

  task automatic scan_char(logic [7:0] c, logic flush);
    logic [5:0] nxt;
    if (flush) begin
      n_flushes++;
      if (scan_st != clsx_pkg::ST_START) begin
        await_token(scan_st);
        scan_st = clsx_pkg::ST_START;
      end
      return;
    end
    if (col_cnt != POS_MAX) col_cnt++;
    if (c == clsx_pkg::CH_NEWLINE) begin
      if (line_cnt != POS_MAX) line_cnt++;
      col_cnt = 16'd0;
    end
    nxt = advance_state(scan_st, c);
    // the terminating byte is rescanned from the start state
    if (scan_st != clsx_pkg::ST_START && nxt == clsx_pkg::ST_START) begin
      await_token(scan_st);
      scan_st = advance_state(clsx_pkg::ST_START, c);
    end else begin
      scan_st = nxt;
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic push_char(logic [7:0] c);
    src_byte_t b;
    b.ch = c;
    b.last = 1'b0;
    b.hold = hold_next;
    hold_next = 1'b0;
    source_bytes.push_back(b);
  endtask

  task automatic push_flush(logic [7:0] c);
    src_byte_t b;
    b.ch = c;
    b.last = 1'b1;
    b.hold = hold_next;
    hold_next = 1'b0;
    source_bytes.push_back(b);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic push_digits(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) push_char(rand_digit());
  endtask

  task automatic add_random_token();
    lex_kind_e kind;
    int n;
    int sel;
    logic [7:0] b;
    string pp;
    kind = lex_kind_e'($urandom_range(0, K_COUNT - 1));
    case (kind)
      K_IDENT: begin
        push_char(rand_letter());
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          sel = $urandom_range(0, 3);
          push_char(sel == 0 ? rand_digit() : (sel == 1 ? 8'("_") : rand_letter()));
        end
      end
      K_INT: push_digits(1, 5);
      K_FLOAT: begin
        push_digits(1, 3);
        push_char(".");
        push_digits(1, 3);
      end
      K_EXP: begin
        push_digits(1, 3);
        if ($urandom_range(0, 1)) begin
          push_char(".");
          push_digits(1, 2);
        end
        push_char($urandom_range(0, 1) ? "e" : "E");
        sel = $urandom_range(0, 2);
        if (sel == 1) push_char("+");
        if (sel == 2) push_char("-");
        push_digits(1, 3);
      end
      K_INCLUDE: push_text("#include");
      K_BROKEN_PP: begin
        n = $urandom_range(1, 7);
        pp = "#include";
        push_text(pp.substr(0, n - 1));
        push_char(rand_letter());
      end
      K_COMMENT: begin
        push_text("//");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          push_char(b == clsx_pkg::CH_NEWLINE ? 8'("z") : b);
        end
        // an unterminated comment is closed by the end flag
        if ($urandom_range(0, 7) == 0) push_flush(8'($urandom_range(0, 255)));
        else push_char(clsx_pkg::CH_NEWLINE);
      end
      K_STRING: begin
        push_char("\"");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          push_char(b == "\"" ? 8'("'") : b);
        end
        if ($urandom_range(0, 7) == 0) push_flush(8'($urandom_range(0, 255)));
        else push_char("\"");
      end
      K_OP: push_text(op_text[$urandom_range(0, 16)]);
      K_OP_PAIR: begin
        push_text(op_text[$urandom_range(0, 16)]);
        push_text(op_text[$urandom_range(0, 16)]);
      end
      K_BROKEN_NUM: begin
        push_digits(1, 2);
        sel = $urandom_range(0, 2);
        if (sel == 0) push_char(".");
        else if (sel == 1) push_char("e");
        else push_text("1.5e-");
        push_char($urandom_range(0, 1) ? rand_letter() : 8'(" "));
      end
      K_SLASH: begin
        push_char("/");
        push_char($urandom_range(0, 1) ? rand_letter() : rand_digit());
      end
      K_NOISE: push_char(8'($urandom_range(0, 255)));
      default: push_flush(8'($urandom_range(0, 255)));
    endcase
    sel = $urandom_range(0, 9);
    if (sel < 5) push_char(" ");
    else if (sel < 7) push_char(clsx_pkg::CH_NEWLINE);
    else if (sel == 7) push_char(8'h09);
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin : drive
    logic calm;
    logic go;
    src_byte_t b;
    calm = (n_chars >= 150 && n_chars < 300);
    if (!rst) begin
      if (!s_axis_tvalid || in_fire) begin
        go = 1'b0;
        if (source_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          // a held byte waits until every token in flight has been taken
          if (!source_bytes[0].hold || awaited_tokens.size() == 0) go = 1'b1;
        end
        if (go) begin
          b = source_bytes.pop_front();
          s_axis_tdata <= b.ch;
          s_axis_tlast <= b.last;
        end
        s_axis_tvalid <= go;
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what, longint got, longint want);
    n_mismatch++;
    if (n_mismatch <= 40)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    lex_token_t t;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_tokens.size() == 0) begin
          report_mismatch("token with none pending, code", m_axis_tdata[8:0], 0);
        end else begin
          t = awaited_tokens.pop_front();
          n_tokens++;
          if (t.err) n_err_tokens++;
          if (m_axis_tdata[8:0] !== t.code) report_mismatch("token code", m_axis_tdata[8:0], t.code);
          if (m_axis_tuser !== t.err) report_mismatch("error flag", m_axis_tuser, t.err);
          if (m_axis_tdata[24:9] !== t.line) report_mismatch("line", m_axis_tdata[24:9], t.line);
          if (m_axis_tdata[40:25] !== t.col) report_mismatch("column", m_axis_tdata[40:25], t.col);
          if (m_axis_tdata[47:41] !== 7'd0) report_mismatch("pad bits", m_axis_tdata[47:41], 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        scan_char(s_axis_tdata, s_axis_tlast);
        n_chars++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : run
    int spin;
    // operators, numbers, directive and comment, then high bytes, flushes and an identifier
    push_text("#include//\n7.2e+9 <=");
    push_char(8'hFF);
    push_char(8'h80);
    push_char(8'h00);
    push_flush(8'hFF);
    push_text("a_Z");
    push_flush(8'h00);

    while (source_bytes.size() < 600) begin
      if (source_bytes.size() >= 220 && source_bytes.size() < 240) hold_next = 1'b1;
      add_random_token();
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (source_bytes.size() != 0 || s_axis_tvalid) @(posedge clk);
    spin = 0;
    while (awaited_tokens.size() != 0 && spin < 1000) begin
      @(posedge clk);
      spin++;
    end
    repeat (10) @(posedge clk);
    if (awaited_tokens.size() != 0)
      report_mismatch("tokens never delivered", 0, awaited_tokens.size());

    $display("covered %0d input bytes (%0d end flags), %0d tokens checked, %0d of them errors",
             n_chars, n_flushes, n_tokens, n_err_tokens);
    $display("position counters reached line %0d, column %0d", line_cnt, col_cnt);
    if (n_mismatch == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
